FILE: rtl/core/swrs_pkg.sv
// package for the sliding window rate statistics unit
// field widths, slice record, sequencer states and request codes; no dependencies
package swrs_pkg;

  localparam int unsigned WINDOW_SECONDS_DEF = 16;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned METRIC_W = 2;
  localparam int unsigned SECS_W   = 5;
  localparam int unsigned AVG_W    = 37;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FRAMES_W = 16;
  localparam int unsigned KBIT_SHIFT = 7;

  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 104;

  typedef enum logic [REQ_W-1:0] {
    REQ_AUDIO = 2'd0,
    REQ_VIDEO = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [METRIC_W-1:0] {
    MET_AUDIO  = 2'd0,
    MET_VIDEO  = 2'd1,
    MET_FRAMES = 2'd2,
    MET_RSVD   = 2'd3
  } metric_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FRAMES_W-1:0] frames;
    logic [VAL_W-1:0]    video;
    logic [VAL_W-1:0]    audio;
  } slice_t;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                              input logic [BYTES_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {{(VAL_W + 1 - BYTES_W){1'b0}}, b};
    return s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/sliding_window_rate_stats_unit.sv
// sliding window bitrate and frame rate meter, top level
// uses swrs_pkg and one swrs_ram instance for the slice ring
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: bytes, metric, seconds; tuser: kind
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: avg, min, max; tuser: has_data
//
// tick: in ST_IDLE; audio or video frame: read in ST_IDLE, modify and write in ST_FRAME
// query: n completed slices walked one per ram read, then a restoring divider giving
// one quotient bit a cycle; an empty window skips both and goes straight to ST_DONE
// reset clears sequencer and slice pointer, sets slice count to one; ring needs no clearing
// a waiting m_axis result holds the next query in its last state, and all of s_axis with it
module sliding_window_rate_stats_unit
  import swrs_pkg::*;
#(
  parameter int unsigned WINDOW_SECONDS = WINDOW_SECONDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // frame_bytes, metric, query_seconds
  input  logic [REQ_W-1:0]    s_axis_tuser,   // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // avg_value, min_value, max_value
  output logic                m_axis_tuser    // has_data
);

  localparam int unsigned DEPTH   = WINDOW_SECONDS + 1;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned HELD_W  = $clog2(DEPTH + 1);
  localparam int unsigned N_W     = $clog2(WINDOW_SECONDS + 1);
  localparam int unsigned SUM_W   = VAL_W + $clog2(WINDOW_SECONDS);
  localparam int unsigned NUM_W   = SUM_W + 1;
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned SLICE_W = $bits(slice_t);

  state_e state_q, state_d;

  logic [SLOT_W-1:0]   newest_q, newest_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic                cur_zero_q, cur_zero_d;
  logic                is_video_q, is_video_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic [METRIC_W-1:0] sel_q, sel_d;
  logic [N_W-1:0]      n_q, n_d;
  logic [N_W-1:0]      left_q, left_d;
  logic [SLOT_W-1:0]   walk_addr_q, walk_addr_d;
  logic                pend_q, pend_d;
  logic                empty_q, empty_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [VAL_W-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [NUM_W-1:0]    div_q, div_d;
  logic [N_W:0]        rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_has_q, out_has_d;
  logic [AVG_W-1:0]    out_avg_q, out_avg_d;
  logic [VAL_W-1:0]    out_min_q, out_min_d, out_max_q, out_max_d;

  logic                accept;
  req_e                req;
  logic [BYTES_W-1:0]  in_bytes;
  logic [METRIC_W-1:0] in_metric;
  logic [SECS_W-1:0]   in_secs;
  logic [N_W-1:0]      secs_eff;
  logic [HELD_W-1:0]   completed;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  slice_t              ram_wdata, ram_rdata, cur_slice;
  logic [VAL_W-1:0]    rd_val;
  logic [N_W:0]        trial;
  logic                load_out;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign req       = req_e'(s_axis_tuser);
  assign in_bytes  = s_axis_tdata[BYTES_W-1:0];
  assign in_metric = s_axis_tdata[BYTES_W +: METRIC_W];
  assign in_secs   = s_axis_tdata[BYTES_W + METRIC_W +: SECS_W];
  assign s_axis_tready = (state_q == ST_IDLE);

  assign secs_eff  = (in_secs == '0 || 32'(in_secs) > WINDOW_SECONDS) ?
                     N_W'(WINDOW_SECONDS) : N_W'(in_secs);
  assign completed = held_q - HELD_W'(1);
  assign cur_slice = cur_zero_q ? slice_t'('0) : ram_rdata;

  swrs_ram #(
    .WIDTH (SLICE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (metric_e'(sel_q))
      MET_AUDIO: rd_val = ram_rdata.audio;
      MET_VIDEO: rd_val = ram_rdata.video;
      default:   rd_val = {{(VAL_W - FRAMES_W){1'b0}}, ram_rdata.frames};
    endcase
  end

  assign trial = {rem_q[N_W-1:0], div_q[NUM_W-1]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req == REQ_AUDIO || req == REQ_VIDEO)) begin
          state_d = ST_FRAME;
        end else if (accept && req == REQ_QUERY) begin
          state_d = (held_q <= HELD_W'(1)) ? ST_DONE : ST_WALK;
        end
      end
      ST_FRAME: state_d = ST_IDLE;
      ST_WALK: begin
        if (left_q == '0 && !pend_q) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // datapath and ram control
  always_comb begin
    newest_d    = newest_q;
    held_d      = held_q;
    cur_zero_d  = cur_zero_q;
    is_video_d  = is_video_q;
    bytes_d     = bytes_q;
    sel_d       = sel_q;
    n_d         = n_q;
    left_d      = left_q;
    walk_addr_d = walk_addr_q;
    pend_d      = 1'b0;
    empty_d     = empty_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = newest_q;
    ram_wdata   = '0;
    ram_raddr   = (state_q == ST_WALK) ? walk_addr_q : newest_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_has_d   = out_has_q;
    out_avg_d   = out_avg_q;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_video_d = (req == REQ_VIDEO);
          bytes_d    = in_bytes;
          sel_d      = (in_metric == MET_RSVD) ? METRIC_W'(MET_FRAMES) : in_metric;
          empty_d    = (held_q <= HELD_W'(1));
          n_d        = (completed < HELD_W'(secs_eff)) ? N_W'(completed) : secs_eff;
          left_d     = n_d;
          walk_addr_d = (newest_q == '0) ? SLOT_W'(WINDOW_SECONDS) : newest_q - SLOT_W'(1);
          sum_d      = '0;
          lo_d       = '1;
          hi_d       = '0;
          if (req == REQ_TICK) begin
            // an untouched slice is made zero before it becomes a completed one
            ram_we     = cur_zero_q;
            ram_wdata  = '0;
            newest_d   = (newest_q == SLOT_W'(WINDOW_SECONDS)) ? '0 : newest_q + SLOT_W'(1);
            cur_zero_d = 1'b1;
            if (held_q < HELD_W'(DEPTH)) begin
              held_d = held_q + HELD_W'(1);
            end
          end
        end
      end
      ST_FRAME: begin
        ram_we    = 1'b1;
        ram_wdata = cur_slice;
        if (is_video_q) begin
          ram_wdata.video = sat_add(cur_slice.video, bytes_q);
          if (cur_slice.frames != '1) begin
            ram_wdata.frames = cur_slice.frames + FRAMES_W'(1);
          end
        end else begin
          ram_wdata.audio = sat_add(cur_slice.audio, bytes_q);
        end
        cur_zero_d = 1'b0;
      end
      ST_WALK: begin
        if (left_q != '0) begin
          left_d      = left_q - N_W'(1);
          walk_addr_d = (walk_addr_q == '0) ? SLOT_W'(WINDOW_SECONDS) :
                        walk_addr_q - SLOT_W'(1);
          pend_d      = 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + SUM_W'(rd_val);
          if (rd_val < lo_q) lo_d = rd_val;
          if (rd_val > hi_q) hi_d = rd_val;
        end
        if (left_q == '0 && !pend_q) begin
          div_d = (sel_q == MET_FRAMES) ? NUM_W'({sum_q, 8'b0}) : NUM_W'({sum_q, 1'b0});
          rem_d = '0;
          cnt_d = CNT_W'(NUM_W);
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, n_q}) begin
          rem_d = trial - {1'b0, n_q};
          div_d = {div_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial;
          div_d = {div_q[NUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_has_d   = !empty_q;
          if (empty_q) begin
            out_avg_d = '0;
            out_min_d = '0;
            out_max_d = '0;
          end else begin
            out_avg_d = AVG_W'(div_q);
            out_min_d = (sel_q == MET_FRAMES) ? lo_q : (lo_q >> KBIT_SHIFT);
            out_max_d = (sel_q == MET_FRAMES) ? hi_q : (hi_q >> KBIT_SHIFT);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      newest_q    <= '0;
      held_q      <= HELD_W'(1);
      cur_zero_q  <= 1'b1;
      pend_q      <= 1'b0;
      left_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      held_q      <= held_d;
      cur_zero_q  <= cur_zero_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_video_q  <= is_video_d;
    bytes_q     <= bytes_d;
    sel_q       <= sel_d;
    n_q         <= n_d;
    walk_addr_q <= walk_addr_d;
    empty_q     <= empty_d;
    sum_q       <= sum_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    out_has_q   <= out_has_d;
    out_avg_q   <= out_avg_d;
    out_min_q   <= out_min_d;
    out_max_q   <= out_max_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tdata  = {{(M_DATA_W - AVG_W - 2 * VAL_W){1'b0}},
                          out_max_q, out_min_q, out_avg_q};

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q >= HELD_W'(1) && held_q <= HELD_W'(DEPTH))
    else $error("slice count out of range");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the final state");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("empty window result carries data");

  a_walk_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (n_q != '0 && 32'(n_q) <= WINDOW_SECONDS && left_q <= n_q))
    else $error("window length out of range during walk");

endmodule

FILE: rtl/core/swrs_ram.sv
// generic single write port ram with registered read
// depends on nothing
module swrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
